/* rtl/core/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, masked while in reset
`define QS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, masked while in reset
`define QS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// next-cycle implication, also checked during reset
`define QS_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/qslerp_pkg.sv */
// types and constants of the quaternion slerp pipeline
package qslerp_pkg;

  localparam int FRAC_BITS = 14;
  localparam int WQ = 30;
  localparam logic [14:0] ONE_Q = 15'(1 << FRAC_BITS);
  localparam logic [30:0] WONE = 31'(1 << WQ);
  localparam logic [14:0] THR_RESET = 15'd16;

  localparam int SQRT_STEPS = 31;
  localparam int ASIN_TERMS = 30;
  localparam int ASIN_STG = 4;
  localparam int SIN_STEPS = 5;
  localparam int SIN_STG = 3;
  localparam int DIV_BITS = 32;

  localparam int S_DOT = 1;
  localparam int S_SUM = 2;
  localparam int S_SQ0 = 3;
  localparam int S_Y2 = S_SQ0 + SQRT_STEPS;
  localparam int S_AS0 = S_Y2 + 1;
  localparam int S_ANG = S_AS0 + ASIN_TERMS * ASIN_STG;
  localparam int S_SX2 = S_ANG + 1;
  localparam int S_HO0 = S_SX2 + 1;
  localparam int S_SF = S_HO0 + SIN_STEPS * SIN_STG;
  localparam int S_DV0 = S_SF + 1;
  localparam int S_KS = S_DV0 + DIV_BITS;
  localparam int S_MUL = S_KS + 1;
  localparam int S_OUT = S_MUL + 1;
  localparam int NST = S_OUT + 1;

  localparam int SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] from_w;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
    logic signed [15:0] to_w;
    logic [14:0] blend;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
  } out_t;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [14:0] t;
    logic lin;
    logic [3:0][31:0] dp;
    logic [61:0] sv;
    logic [61:0] sr;
    logic [29:0] y2;
    logic [29:0] term;
    logic [41:0] tx;
    logic [2:0][3:0][43:0] pp;
    logic [31:0] asum;
    logic [2:0][30:0] sx;
    logic [2:0][31:0] sx2;
    logic [2:0][32:0] sp;
    logic [2:0][30:0] hr;
    logic [2:0][30:0] sn;
    logic [1:0][30:0] rem;
    logic [1:0][31:0] qt;
    logic [1:0][31:0] k;
    logic [3:0][1:0][50:0] mp;
    logic [3:0][15:0] res;
  } pl_t;

endpackage

/* rtl/core/quaternion_slerp_top.sv */
// quaternion slerp, fully pipelined, one transfer per cycle while the output is not stalled
//
//  channel  ports                        direction
//  in       in_valid in_ready in_data    two quaternions and blend factor
//  out      out_valid out_ready out_data interpolated quaternion
//  cfg      cfg_we cfg_data              linear threshold write
//
// one item enters per cycle while the output is not stalled
// depth is set by the 31 square root steps, 30 arcsine terms, sine evaluation
// and the 32 bit restoring divider; square root and divider take one step per stage
// reset is synchronous, clears valid bits and sets the threshold to 16
// a stalled output freezes all stages; an empty first stage still takes input
module quaternion_slerp_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qslerp_pkg::in_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qslerp_pkg::out_t   out_data,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_data
);

  localparam int NST = qslerp_pkg::NST;

  qslerp_pkg::pl_t st_r [NST];
  qslerp_pkg::pl_t st_nxt [NST];
  logic [NST-1:0] vld_r;
  logic [14:0] thr_r;
  logic en;
  logic en0;

  function automatic logic [3:0][43:0] cdiv_pp(input logic [41:0] x, input logic [42:0] m);
    logic [3:0][43:0] p;
    p[3] = {23'b0, x[41:21]} * {22'b0, m[42:21]};
    p[2] = {23'b0, x[41:21]} * {23'b0, m[20:0]};
    p[1] = {23'b0, x[20:0]} * {22'b0, m[42:21]};
    p[0] = {23'b0, x[20:0]} * {23'b0, m[20:0]};
    return p;
  endfunction

  function automatic logic [41:0] cdiv_q(input logic [3:0][43:0] p, input int unsigned s);
    logic [85:0] f;
    f = ({42'b0, p[3]} << 42) + (({42'b0, p[2]} + {42'b0, p[1]}) << 21) + {42'b0, p[0]};
    return 42'(f >> s);
  endfunction

  assign en = !vld_r[NST-1] || out_ready;
  assign en0 = en || !vld_r[0];
  assign in_ready = en0;
  assign out_valid = vld_r[NST-1];
  assign out_data.out_x = st_r[NST-1].res[0];
  assign out_data.out_y = st_r[NST-1].res[1];
  assign out_data.out_z = st_r[NST-1].res[2];
  assign out_data.out_w = st_r[NST-1].res[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= qslerp_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en0) begin
        vld_r[0] <= in_valid;
      end
      if (en) begin
        vld_r[NST-1:1] <= vld_r[NST-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      st_r[0] <= st_nxt[0];
    end
  end

  for (genvar i = 1; i < NST; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // input capture
  always_comb begin
    st_nxt[0] = '0;
    st_nxt[0].a[0] = in_data.from_x;
    st_nxt[0].a[1] = in_data.from_y;
    st_nxt[0].a[2] = in_data.from_z;
    st_nxt[0].a[3] = in_data.from_w;
    st_nxt[0].b[0] = {in_data.to_x[15], in_data.to_x};
    st_nxt[0].b[1] = {in_data.to_y[15], in_data.to_y};
    st_nxt[0].b[2] = {in_data.to_z[15], in_data.to_z};
    st_nxt[0].b[3] = {in_data.to_w[15], in_data.to_w};
    st_nxt[0].t = (in_data.blend > qslerp_pkg::ONE_Q) ? qslerp_pkg::ONE_Q : in_data.blend;
  end

  // dot product terms
  always_comb begin
    st_nxt[qslerp_pkg::S_DOT] = st_r[qslerp_pkg::S_DOT-1];
    for (int j = 0; j < 4; j++) begin
      st_nxt[qslerp_pkg::S_DOT].dp[j] =
        32'($signed(st_r[qslerp_pkg::S_DOT-1].a[j]) *
            $signed(st_r[qslerp_pkg::S_DOT-1].b[j][15:0]));
    end
  end

  // sum, shortest arc, cosine clamp, linear decision, square root operand
  logic signed [33:0] s2_sum;
  logic [33:0] s2_abs;
  logic [19:0] s2_cf;
  logic [14:0] s2_c;
  logic [14:0] s2_d;
  logic [30:0] s2_u;
  always_comb begin
    st_nxt[qslerp_pkg::S_SUM] = st_r[qslerp_pkg::S_SUM-1];
    s2_sum = '0;
    for (int j = 0; j < 4; j++) begin
      s2_sum = s2_sum + 34'($signed(st_r[qslerp_pkg::S_SUM-1].dp[j]));
    end
    s2_abs = s2_sum[33] ? 34'(-s2_sum) : 34'(s2_sum);
    s2_cf = 20'(s2_abs >> qslerp_pkg::FRAC_BITS);
    s2_c = (s2_cf > {5'b0, qslerp_pkg::ONE_Q}) ? qslerp_pkg::ONE_Q : s2_cf[14:0];
    s2_d = qslerp_pkg::ONE_Q - s2_c;
    s2_u = (qslerp_pkg::WONE - {s2_c, 16'b0}) >> 1;
    st_nxt[qslerp_pkg::S_SUM].lin = !(s2_d > thr_r);
    if (s2_sum[33]) begin
      for (int j = 0; j < 4; j++) begin
        st_nxt[qslerp_pkg::S_SUM].b[j] = 17'(-st_r[qslerp_pkg::S_SUM-1].b[j]);
      end
    end
    st_nxt[qslerp_pkg::S_SUM].sv = {2'b0, s2_u[29:0], 30'b0};
    st_nxt[qslerp_pkg::S_SUM].sr = '0;
  end

  // floor square root, one bit pair per stage
  for (genvar j = 0; j < qslerp_pkg::SQRT_STEPS; j++) begin : g_sqrt
    localparam int I = qslerp_pkg::S_SQ0 + j;
    localparam logic [61:0] BB = 62'(1) << (2 * (qslerp_pkg::SQRT_STEPS - 1 - j));
    logic [61:0] trial;
    always_comb begin
      st_nxt[I] = st_r[I-1];
      trial = st_r[I-1].sr + BB;
      if (st_r[I-1].sv >= trial) begin
        st_nxt[I].sv = st_r[I-1].sv - trial;
        st_nxt[I].sr = (st_r[I-1].sr >> 1) + BB;
      end else begin
        st_nxt[I].sr = st_r[I-1].sr >> 1;
      end
    end
  end

  // arcsine series setup
  logic [59:0] y2_prod;
  always_comb begin
    st_nxt[qslerp_pkg::S_Y2] = st_r[qslerp_pkg::S_Y2-1];
    y2_prod = {30'b0, st_r[qslerp_pkg::S_Y2-1].sr[29:0]} *
              {30'b0, st_r[qslerp_pkg::S_Y2-1].sr[29:0]};
    st_nxt[qslerp_pkg::S_Y2].y2 = y2_prod[59:30];
    st_nxt[qslerp_pkg::S_Y2].term = st_r[qslerp_pkg::S_Y2-1].sr[29:0];
    st_nxt[qslerp_pkg::S_Y2].asum = {2'b0, st_r[qslerp_pkg::S_Y2-1].sr[29:0]};
  end

  // arcsine terms, four stages each
  for (genvar n = 0; n < qslerp_pkg::ASIN_TERMS; n++) begin : g_asin
    localparam int B0 = qslerp_pkg::S_AS0 + n * qslerp_pkg::ASIN_STG;
    localparam logic [11:0] ODD2 = 12'((2 * n + 1) * (2 * n + 1));
    localparam longint unsigned DEN = longint'((2 * n + 2) * (2 * n + 3));
    localparam int SH = 42 + $clog2(DEN);
    localparam longint unsigned MV = ((64'd1 << SH) + DEN - 64'd1) / DEN;
    logic [59:0] tp;
    logic [41:0] q;
    always_comb begin
      st_nxt[B0] = st_r[B0-1];
      tp = {30'b0, st_r[B0-1].term} * {30'b0, st_r[B0-1].y2};
      st_nxt[B0].term = tp[59:30];
    end
    always_comb begin
      st_nxt[B0+1] = st_r[B0];
      st_nxt[B0+1].tx = {12'b0, st_r[B0].term} * {30'b0, ODD2};
    end
    always_comb begin
      st_nxt[B0+2] = st_r[B0+1];
      st_nxt[B0+2].pp[0] = cdiv_pp(st_r[B0+1].tx, MV[42:0]);
    end
    always_comb begin
      st_nxt[B0+3] = st_r[B0+2];
      q = cdiv_q(st_r[B0+2].pp[0], SH);
      st_nxt[B0+3].term = q[29:0];
      st_nxt[B0+3].asum = st_r[B0+2].asum + q[31:0];
    end
  end

  // theta and the two partial angles
  logic [30:0] an_theta;
  logic [30:0] an_t30;
  logic [61:0] an_p0;
  logic [61:0] an_p1;
  always_comb begin
    st_nxt[qslerp_pkg::S_ANG] = st_r[qslerp_pkg::S_ANG-1];
    an_theta = {st_r[qslerp_pkg::S_ANG-1].asum[29:0], 1'b0};
    an_t30 = {st_r[qslerp_pkg::S_ANG-1].t, 16'b0};
    an_p0 = {31'b0, an_theta} * {31'b0, qslerp_pkg::WONE - an_t30};
    an_p1 = {31'b0, an_theta} * {31'b0, an_t30};
    st_nxt[qslerp_pkg::S_ANG].sx[0] = an_theta;
    st_nxt[qslerp_pkg::S_ANG].sx[1] = an_p0[60:30];
    st_nxt[qslerp_pkg::S_ANG].sx[2] = an_p1[60:30];
  end

  // squares of the angles
  logic [2:0][61:0] sq_p;
  always_comb begin
    st_nxt[qslerp_pkg::S_SX2] = st_r[qslerp_pkg::S_SX2-1];
    for (int l = 0; l < 3; l++) begin
      sq_p[l] = {31'b0, st_r[qslerp_pkg::S_SX2-1].sx[l]} *
                {31'b0, st_r[qslerp_pkg::S_SX2-1].sx[l]};
      st_nxt[qslerp_pkg::S_SX2].sx2[l] = sq_p[l][61:30];
      st_nxt[qslerp_pkg::S_SX2].hr[l] = qslerp_pkg::WONE;
    end
  end

  // sine polynomial, three lanes, three stages per step
  for (genvar h = 0; h < qslerp_pkg::SIN_STEPS; h++) begin : g_sin
    localparam int B0 = qslerp_pkg::S_HO0 + h * qslerp_pkg::SIN_STG;
    localparam longint unsigned DEN = longint'(qslerp_pkg::SIN_DIV[h]);
    localparam int SH = 42 + $clog2(DEN);
    localparam longint unsigned MV = ((64'd1 << SH) + DEN - 64'd1) / DEN;
    logic [2:0][62:0] hp;
    logic [2:0][41:0] q;
    always_comb begin
      st_nxt[B0] = st_r[B0-1];
      for (int l = 0; l < 3; l++) begin
        hp[l] = {32'b0, st_r[B0-1].hr[l]} * {31'b0, st_r[B0-1].sx2[l]};
        st_nxt[B0].sp[l] = hp[l][62:30];
      end
    end
    always_comb begin
      st_nxt[B0+1] = st_r[B0];
      for (int l = 0; l < 3; l++) begin
        st_nxt[B0+1].pp[l] = cdiv_pp({9'b0, st_r[B0].sp[l]}, MV[42:0]);
      end
    end
    always_comb begin
      st_nxt[B0+2] = st_r[B0+1];
      for (int l = 0; l < 3; l++) begin
        q[l] = cdiv_q(st_r[B0+1].pp[l], SH);
        st_nxt[B0+2].hr[l] = (q[l] >= {11'b0, qslerp_pkg::WONE}) ? 31'b0 :
                             31'(qslerp_pkg::WONE - q[l][30:0]);
      end
    end
  end

  // final sine products
  logic [2:0][61:0] sf_p;
  always_comb begin
    st_nxt[qslerp_pkg::S_SF] = st_r[qslerp_pkg::S_SF-1];
    for (int l = 0; l < 3; l++) begin
      sf_p[l] = {31'b0, st_r[qslerp_pkg::S_SF-1].hr[l]} *
                {31'b0, st_r[qslerp_pkg::S_SF-1].sx[l]};
      st_nxt[qslerp_pkg::S_SF].sn[l] = sf_p[l][60:30];
    end
  end

  // restoring divide of the partial sines by sin(theta), one quotient bit per stage
  for (genvar j = 0; j < qslerp_pkg::DIV_BITS; j++) begin : g_div
    localparam int I = qslerp_pkg::S_DV0 + j;
    localparam int QB = qslerp_pkg::DIV_BITS - 1 - j;
    logic [1:0][30:0] rin;
    logic [1:0] nbit;
    logic [1:0][31:0] rem2;
    always_comb begin
      st_nxt[I] = st_r[I-1];
      for (int l = 0; l < 2; l++) begin
        if (j == 0) begin
          rin[l] = {2'b0, st_r[I-1].sn[l+1][30:2]};
          st_nxt[I].qt[l] = '0;
        end else begin
          rin[l] = st_r[I-1].rem[l];
        end
        if (QB == 31) begin
          nbit[l] = st_r[I-1].sn[l+1][1];
        end else if (QB == 30) begin
          nbit[l] = st_r[I-1].sn[l+1][0];
        end else begin
          nbit[l] = 1'b0;
        end
        rem2[l] = {rin[l], nbit[l]};
        if (rem2[l] >= {1'b0, st_r[I-1].sn[0]}) begin
          st_nxt[I].rem[l] = 31'(rem2[l] - {1'b0, st_r[I-1].sn[0]});
          st_nxt[I].qt[l][QB] = 1'b1;
        end else begin
          st_nxt[I].rem[l] = rem2[l][30:0];
          st_nxt[I].qt[l][QB] = 1'b0;
        end
      end
    end
  end

  // weight select
  logic ks_lin;
  always_comb begin
    st_nxt[qslerp_pkg::S_KS] = st_r[qslerp_pkg::S_KS-1];
    ks_lin = st_r[qslerp_pkg::S_KS-1].lin || (st_r[qslerp_pkg::S_KS-1].sn[0] == '0);
    if (ks_lin) begin
      st_nxt[qslerp_pkg::S_KS].k[0] =
        {1'b0, qslerp_pkg::ONE_Q - st_r[qslerp_pkg::S_KS-1].t, 16'b0};
      st_nxt[qslerp_pkg::S_KS].k[1] = {1'b0, st_r[qslerp_pkg::S_KS-1].t, 16'b0};
    end else begin
      st_nxt[qslerp_pkg::S_KS].k[0] = st_r[qslerp_pkg::S_KS-1].qt[0];
      st_nxt[qslerp_pkg::S_KS].k[1] = st_r[qslerp_pkg::S_KS-1].qt[1];
    end
  end

  // weighted products
  always_comb begin
    st_nxt[qslerp_pkg::S_MUL] = st_r[qslerp_pkg::S_MUL-1];
    for (int j = 0; j < 4; j++) begin
      st_nxt[qslerp_pkg::S_MUL].mp[j][0] =
        51'($signed(st_r[qslerp_pkg::S_MUL-1].a[j]) *
            $signed({1'b0, st_r[qslerp_pkg::S_MUL-1].k[0]}));
      st_nxt[qslerp_pkg::S_MUL].mp[j][1] =
        51'($signed(st_r[qslerp_pkg::S_MUL-1].b[j]) *
            $signed({1'b0, st_r[qslerp_pkg::S_MUL-1].k[1]}));
    end
  end

  // sum, round, saturate
  logic signed [3:0][51:0] o_v;
  logic signed [3:0][21:0] o_r;
  always_comb begin
    st_nxt[qslerp_pkg::S_OUT] = st_r[qslerp_pkg::S_OUT-1];
    for (int j = 0; j < 4; j++) begin
      o_v[j] = 52'($signed(st_r[qslerp_pkg::S_OUT-1].mp[j][0])) +
               52'($signed(st_r[qslerp_pkg::S_OUT-1].mp[j][1])) +
               52'(1 << (qslerp_pkg::WQ - 1));
      o_r[j] = o_v[j][51:30];
      if ($signed(o_r[j]) > 22'sd32767) begin
        st_nxt[qslerp_pkg::S_OUT].res[j] = 16'h7fff;
      end else if ($signed(o_r[j]) < -22'sd32768) begin
        st_nxt[qslerp_pkg::S_OUT].res[j] = 16'h8000;
      end else begin
        st_nxt[qslerp_pkg::S_OUT].res[j] = o_r[j][15:0];
      end
    end
  end

endmodule

/* rtl/core/qslerp_chk.sv */
// port checker for the quaternion slerp top level, with its bind
`include "assert_macros.svh"

module qslerp_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input qslerp_pkg::in_t  in_data,
  input logic             out_valid,
  input logic             out_ready,
  input qslerp_pkg::out_t out_data,
  input logic             cfg_we,
  input logic [14:0]      cfg_data
);

  // no result right after reset
  `QS_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid)
  // input side never blocks while the output can move
  `QS_ASSERT_NOW(a_in_free, clk, rst_n, !out_valid || out_ready, in_ready)
  // a stalled result holds
  `QS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // a result leaves only through a transfer
  `QS_ASSERT_NOW(a_out_leave, clk, rst_n, $fell(out_valid), $past(out_ready))

endmodule

bind quaternion_slerp_top qslerp_chk u_qslerp_chk (.*);
